// ===== design/tws_pkg.sv =====
package tws_pkg;

  localparam int INDEX_BITS  = 12;
  localparam int VALUE_BITS  = 32;
  localparam int LEVEL_BITS  = 8;
  localparam int STACK_DEPTH = 255;

  localparam int ENTRY_DEPTH = 1 << INDEX_BITS;
  localparam int PTR_BITS    = $clog2(STACK_DEPTH);
  localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_SET     = 2'd1,
    CMD_RESTORE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_GET,
    ST_SAVE,
    ST_WALK,
    ST_POP,
    ST_FINISH
  } state_t;

  // One table word: a written flag selects the stored value over the default
  typedef struct packed {
    logic                  written;
    logic [VALUE_BITS-1:0] value;
  } entry_word_t;

  // One save record
  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic [VALUE_BITS-1:0] value;
    logic [LEVEL_BITS-1:0] level;
    logic                  skipped;
  } save_rec_t;

  typedef struct packed {
    logic                  rd_en;
    logic [INDEX_BITS-1:0] rd_addr;
    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_addr;
    entry_word_t           wr_data;
  } entry_req_t;

  typedef struct packed {
    logic                rd_en;
    logic [PTR_BITS-1:0] rd_addr;
    logic                wr_en;
    logic [PTR_BITS-1:0] wr_addr;
    save_rec_t           wr_data;
  } stack_req_t;

endpackage

// ===== design/table_with_level_save_stack_unit.sv =====
// Steps per request: get reads the entry, then returns it; set above level 1 reads the
// old value, then pushes it and writes the new one; set at level 1 or below writes the
// entry, then walks the stack to mark its records skipped; restore pops records in turn.
// One request in flight at a time; the next is taken once the result is loaded, and
// a result still waiting for the receiver holds the block. Reset (synchronous) empties
// the stack, zeroes the default and then sweeps the table, marking every entry unwritten.
module table_with_level_save_stack_unit
  import tws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [VALUE_BITS-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  input  logic [INDEX_BITS-1:0] index,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [LEVEL_BITS-1:0] level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] read_value,
  output logic                  overflow,
  output logic [COUNT_BITS-1:0] stack_count
);

  entry_req_t  entry_req;
  entry_word_t entry_rdata;
  stack_req_t  stack_req;
  save_rec_t   stack_rdata;

  // Sequencer
  tws_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .index       (index),
    .value       (value),
    .level       (level),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_value  (read_value),
    .overflow    (overflow),
    .stack_count (stack_count),
    .entry_req   (entry_req),
    .entry_rdata (entry_rdata),
    .stack_req   (stack_req),
    .stack_rdata (stack_rdata)
  );

  // Table memory
  tws_ram #(
    .WIDTH ($bits(entry_word_t)),
    .DEPTH (ENTRY_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .rd_en   (entry_req.rd_en),
    .rd_addr (entry_req.rd_addr),
    .rd_data (entry_rdata),
    .wr_en   (entry_req.wr_en),
    .wr_addr (entry_req.wr_addr),
    .wr_data (entry_req.wr_data)
  );

  // Save stack memory
  tws_ram #(
    .WIDTH ($bits(save_rec_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .rd_en   (stack_req.rd_en),
    .rd_addr (stack_req.rd_addr),
    .rd_data (stack_rdata),
    .wr_en   (stack_req.wr_en),
    .wr_addr (stack_req.wr_addr),
    .wr_data (stack_req.wr_data)
  );

`ifndef SYNTHESIS
  // Overflow is only reported with the stack full
  assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> stack_count == COUNT_BITS'(STACK_DEPTH))
    else $error("overflow reported with stack not full");

  // Stack count never exceeds the depth
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stack_count <= COUNT_BITS'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // One request at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // No request during the clearing pass after reset
  assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !in_ready)
    else $error("ready during clearing pass");
`endif

endmodule

// ===== design/tws_ram.sv =====
module tws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; hold the last word when not reading
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/tws_ctrl.sv =====
module tws_ctrl
  import tws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [VALUE_BITS-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  input  logic [INDEX_BITS-1:0] index,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [LEVEL_BITS-1:0] level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] read_value,
  output logic                  overflow,
  output logic [COUNT_BITS-1:0] stack_count,
  output entry_req_t            entry_req,
  input  entry_word_t           entry_rdata,
  output stack_req_t            stack_req,
  input  save_rec_t             stack_rdata
);

  state_t                state, state_next;
  logic [INDEX_BITS-1:0] init_cnt, init_cnt_next;
  logic [INDEX_BITS-1:0] idx_q, idx_q_next;
  logic [VALUE_BITS-1:0] val_q, val_q_next;
  logic [LEVEL_BITS-1:0] lvl_q, lvl_q_next;
  logic [COUNT_BITS-1:0] top, top_next;
  logic                  ovf_q, ovf_q_next;
  logic [COUNT_BITS-1:0] walk_ptr, walk_ptr_next;
  logic                  chk_valid, chk_valid_next;
  logic [PTR_BITS-1:0]   chk_addr, chk_addr_next;
  logic [VALUE_BITS-1:0] default_value;
  logic                  out_valid_next;
  logic [VALUE_BITS-1:0] read_value_next;
  logic                  overflow_next;
  logic [COUNT_BITS-1:0] stack_count_next;

  logic                  accept;
  logic                  out_free;
  cmd_t                  in_cmd;
  logic                  low_level;
  logic                  pop;
  logic [COUNT_BITS-1:0] top_m1, top_m2;
  logic [VALUE_BITS-1:0] entry_val;

  assign in_cmd    = cmd_t'(command);
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign low_level = (level <= LEVEL_BITS'(1));
  assign pop       = (stack_rdata.level >= lvl_q);
  assign top_m1    = top - COUNT_BITS'(1);
  assign top_m2    = top - COUNT_BITS'(2);
  assign entry_val = entry_rdata.written ? entry_rdata.value : default_value;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (init_cnt == {INDEX_BITS{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_GET: state_next = ST_GET;
            CMD_SET: begin
              if (!low_level) state_next = ST_SAVE;
              else if (top == '0) state_next = ST_FINISH;
              else state_next = ST_WALK;
            end
            CMD_RESTORE: state_next = (top == '0) ? ST_FINISH : ST_POP;
            CMD_CLEAR: state_next = ST_FINISH;
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_GET: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_SAVE: state_next = ST_FINISH;
      ST_WALK: begin
        if (walk_ptr == top && !chk_valid) state_next = ST_FINISH;
      end
      ST_POP: begin
        if (!pop || top == COUNT_BITS'(1)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory requests and datapath updates
  always_comb begin
    entry_req        = '0;
    stack_req        = '0;
    init_cnt_next    = init_cnt;
    idx_q_next       = idx_q;
    val_q_next       = val_q;
    lvl_q_next       = lvl_q;
    top_next         = top;
    ovf_q_next       = ovf_q;
    walk_ptr_next    = walk_ptr;
    chk_valid_next   = chk_valid;
    chk_addr_next    = chk_addr;
    out_valid_next   = out_valid && !out_ready;
    read_value_next  = read_value;
    overflow_next    = overflow;
    stack_count_next = stack_count;
    case (state)
      // Sweep the table, marking every entry unwritten
      ST_INIT: begin
        entry_req.wr_en   = 1'b1;
        entry_req.wr_addr = init_cnt;
        entry_req.wr_data = '0;
        init_cnt_next     = init_cnt + INDEX_BITS'(1);
      end
      // Take a request and start its first memory access, if it has one
      ST_IDLE: begin
        if (accept) begin
          idx_q_next = index;
          val_q_next = value;
          lvl_q_next = level;
          ovf_q_next = 1'b0;
          case (in_cmd)
            CMD_GET: begin
              entry_req.rd_en   = 1'b1;
              entry_req.rd_addr = index;
            end
            CMD_SET: begin
              if (low_level) begin
                entry_req.wr_en         = 1'b1;
                entry_req.wr_addr       = index;
                entry_req.wr_data.written = 1'b1;
                entry_req.wr_data.value = value;
                walk_ptr_next           = '0;
                chk_valid_next          = 1'b0;
              end else begin
                entry_req.rd_en   = 1'b1;
                entry_req.rd_addr = index;
              end
            end
            CMD_RESTORE: begin
              if (top != '0) begin
                stack_req.rd_en   = 1'b1;
                stack_req.rd_addr = top_m1[PTR_BITS-1:0];
              end
            end
            CMD_CLEAR: top_next = '0;
            default: top_next = top;
          endcase
        end
      end
      // Return the entry once the output slot is free
      ST_GET: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          read_value_next  = entry_val;
          overflow_next    = 1'b0;
          stack_count_next = top;
        end
      end
      // Push the old value, or drop the record when full, and write the new value
      ST_SAVE: begin
        entry_req.wr_en           = 1'b1;
        entry_req.wr_addr         = idx_q;
        entry_req.wr_data.written = 1'b1;
        entry_req.wr_data.value   = val_q;
        if (top < COUNT_BITS'(STACK_DEPTH)) begin
          stack_req.wr_en           = 1'b1;
          stack_req.wr_addr         = top[PTR_BITS-1:0];
          stack_req.wr_data.index   = idx_q;
          stack_req.wr_data.value   = entry_val;
          stack_req.wr_data.level   = lvl_q;
          stack_req.wr_data.skipped = 1'b0;
          top_next                  = top + COUNT_BITS'(1);
        end else begin
          ovf_q_next = 1'b1;
        end
      end
      // Scan records bottom up: read one, check the previous, mark matches
      ST_WALK: begin
        if (walk_ptr < top) begin
          stack_req.rd_en   = 1'b1;
          stack_req.rd_addr = walk_ptr[PTR_BITS-1:0];
          walk_ptr_next     = walk_ptr + COUNT_BITS'(1);
          chk_valid_next    = 1'b1;
          chk_addr_next     = walk_ptr[PTR_BITS-1:0];
        end else begin
          chk_valid_next = 1'b0;
        end
        if (chk_valid && stack_rdata.index == idx_q) begin
          stack_req.wr_en           = 1'b1;
          stack_req.wr_addr         = chk_addr;
          stack_req.wr_data         = stack_rdata;
          stack_req.wr_data.skipped = 1'b1;
        end
      end
      // Pop the top record if its level is high enough, restoring it unless skipped; fetch the next one
      ST_POP: begin
        if (pop) begin
          if (!stack_rdata.skipped) begin
            entry_req.wr_en           = 1'b1;
            entry_req.wr_addr         = stack_rdata.index;
            entry_req.wr_data.written = 1'b1;
            entry_req.wr_data.value   = stack_rdata.value;
          end
          top_next = top_m1;
          if (top != COUNT_BITS'(1)) begin
            stack_req.rd_en   = 1'b1;
            stack_req.rd_addr = top_m2[PTR_BITS-1:0];
          end
        end
      end
      // Report the stack state for set, restore and clear
      ST_FINISH: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          read_value_next  = '0;
          overflow_next    = ovf_q;
          stack_count_next = top;
        end
      end
      default: begin
        entry_req = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      init_cnt      <= '0;
      top           <= '0;
      chk_valid     <= 1'b0;
      out_valid     <= 1'b0;
      default_value <= '0;
    end else begin
      state     <= state_next;
      init_cnt  <= init_cnt_next;
      top       <= top_next;
      chk_valid <= chk_valid_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        default_value <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_q       <= idx_q_next;
    val_q       <= val_q_next;
    lvl_q       <= lvl_q_next;
    ovf_q       <= ovf_q_next;
    walk_ptr    <= walk_ptr_next;
    chk_addr    <= chk_addr_next;
    read_value  <= read_value_next;
    overflow    <= overflow_next;
    stack_count <= stack_count_next;
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import tws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int FILL_SETS   = STACK_DEPTH + 5;

  // One result as the block reports it
  typedef struct packed {
    logic [VALUE_BITS-1:0] read_value;
    logic                  overflow;
    logic [COUNT_BITS-1:0] stack_count;
  } table_result_t;

  // Shadow of the table and its save stack; predicts one result per request
  class table_tracker;
    logic [VALUE_BITS-1:0] default_word;
    logic [VALUE_BITS-1:0] words [ENTRY_DEPTH];
    bit                    written [ENTRY_DEPTH];
    save_rec_t             records [STACK_DEPTH];
    int unsigned           top;
    table_result_t         expected_results [$];
    int                    errors;

    function new();
      default_word = '0;
      top          = 0;
      errors       = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function logic [VALUE_BITS-1:0] lookup(logic [INDEX_BITS-1:0] idx);
      return written[idx] ? words[idx] : default_word;
    endfunction

    function void store(logic [INDEX_BITS-1:0] idx, logic [VALUE_BITS-1:0] val);
      words[idx]   = val;
      written[idx] = 1'b1;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_request(logic [1:0] cmd, logic [INDEX_BITS-1:0] idx,
                               logic [VALUE_BITS-1:0] val, logic [LEVEL_BITS-1:0] lvl);
      table_result_t res;
      res = '0;
      case (cmd_t'(cmd))
        CMD_GET: begin
          res.read_value = lookup(idx);
        end
        CMD_SET: begin
          if (lvl <= 1) begin
            // Low-level set: mark every saved record of this entry as skipped
            for (int p = 0; p < top; p++)
              if (records[p].index == idx) records[p].skipped = 1'b1;
          end else if (top < STACK_DEPTH) begin
            records[top] = '{index: idx, value: lookup(idx), level: lvl, skipped: 1'b0};
            top++;
          end else begin
            res.overflow = 1'b1;
          end
          store(idx, val);
        end
        CMD_RESTORE: begin
          // Pop records at or above the level, writing back the live ones
          while (top > 0 && records[top-1].level >= lvl) begin
            top--;
            if (!records[top].skipped) store(records[top].index, records[top].value);
          end
        end
        default: begin
          top = 0;
        end
      endcase
      res.stack_count = top[COUNT_BITS-1:0];
      expected_results.push_back(res);
    endfunction

    function void check_result(table_result_t got);
      table_result_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request outstanding: read_value %h overflow %b count %0d",
                 $time, got.read_value, got.overflow, got.stack_count);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.read_value !== exp_r.read_value) begin
        $display("%0t: read_value mismatch: expected %h, actual %h",
                 $time, exp_r.read_value, got.read_value);
        errors++;
      end
      if (got.overflow !== exp_r.overflow) begin
        $display("%0t: overflow mismatch: expected %b, actual %b",
                 $time, exp_r.overflow, got.overflow);
        errors++;
      end
      if (got.stack_count !== exp_r.stack_count) begin
        $display("%0t: stack_count mismatch: expected %0d, actual %0d",
                 $time, exp_r.stack_count, got.stack_count);
        errors++;
      end
    endfunction
  endclass

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_wr_en   = 1'b0;
  logic [VALUE_BITS-1:0] cfg_wr_data = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [1:0]            command     = CMD_GET;
  logic [INDEX_BITS-1:0] index       = '0;
  logic [VALUE_BITS-1:0] value       = '0;
  logic [LEVEL_BITS-1:0] level       = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [VALUE_BITS-1:0] read_value;
  logic                  overflow;
  logic [COUNT_BITS-1:0] stack_count;

  int          tx_idle_pct  = 37;
  int          rx_idle_pct  = 73;
  int          hold_trigger = 0;
  int          hold_seen    = 0;
  int          hold_left    = 0;
  int unsigned cycle_count  = 0;
  int          requests_sent = 0;

  table_tracker tracker = new();

  table_with_level_save_stack_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .index       (index),
    .value       (value),
    .level       (level),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_value  (read_value),
    .overflow    (overflow),
    .stack_count (stack_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random back-pressure, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Check each result as it is taken
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_result('{read_value: read_value, overflow: overflow,
                             stack_count: stack_count});
  end

  // Offer one request and hold it until accepted
  task automatic send(logic [1:0] cmd, logic [INDEX_BITS-1:0] idx,
                      logic [VALUE_BITS-1:0] val, logic [LEVEL_BITS-1:0] lvl);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    index    <= idx;
    value    <= val;
    level    <= lvl;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(cmd, idx, val, lvl);
    requests_sent++;
  endtask

  // Drop valid and wait until every result is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_default(logic [VALUE_BITS-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.default_word = v;
  endtask

  // Mostly a small window so that entries are revisited
  function automatic logic [INDEX_BITS-1:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return INDEX_BITS'($urandom_range(0, 15));
    if (r < 70) return ($urandom_range(0, 1) == 1) ? '1 : '0;
    return INDEX_BITS'($urandom);
  endfunction

  task automatic send_noise();
    send(2'($urandom_range(0, 3)), INDEX_BITS'($urandom), $urandom,
         LEVEL_BITS'($urandom_range(0, 255)));
  endtask

  // One nested group: sets and gets around a base level, then usually a restore
  task automatic send_group();
    int base;
    int n;
    int r;
    base = $urandom_range(2, 40);
    n    = $urandom_range(3, 12);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        send(CMD_SET, pick_index(), $urandom, LEVEL_BITS'(base + $urandom_range(0, 3)));
      else if (r < 75)
        send(CMD_GET, pick_index(), $urandom, LEVEL_BITS'($urandom));
      else if (r < 87)
        send(CMD_SET, pick_index(), $urandom, LEVEL_BITS'($urandom_range(0, 1)));
      else if (r < 95)
        send(CMD_RESTORE, INDEX_BITS'($urandom), $urandom,
             LEVEL_BITS'(base + $urandom_range(0, 3)));
      else
        send_noise();
    end
    r = $urandom_range(0, 99);
    if (r < 70)
      send(CMD_RESTORE, INDEX_BITS'($urandom), $urandom, LEVEL_BITS'(base));
    else if (r < 90)
      send(CMD_RESTORE, INDEX_BITS'($urandom), $urandom, LEVEL_BITS'($urandom_range(0, 1)));
    else if (r < 95)
      send(CMD_CLEAR, INDEX_BITS'($urandom), $urandom, LEVEL_BITS'($urandom));
  endtask

  // Push past the stack depth, then walk and unwind the full stack
  task automatic send_fill();
    for (int i = 0; i < FILL_SETS; i++)
      send(CMD_SET, pick_index(), $urandom, LEVEL_BITS'($urandom_range(2, 255)));
    send(CMD_GET, pick_index(), $urandom, '0);
    send(CMD_SET, pick_index(), $urandom, LEVEL_BITS'($urandom_range(0, 1)));
    send(CMD_RESTORE, '0, '0, 8'd128);
    send(CMD_RESTORE, '0, '0, 8'd1);
  endtask

  task automatic run_phase(int target, bit with_fill, bit with_hold);
    int start;
    bit filled;
    bit held;
    start  = requests_sent;
    filled = 1'b0;
    held   = 1'b0;
    while (requests_sent - start < target) begin
      if (with_hold && !held && requests_sent - start >= 100) begin
        hold_trigger <= hold_trigger + 1;
        held = 1'b1;
      end
      if (with_fill && !filled && requests_sent - start >= 50) begin
        send_fill();
        filled = 1'b1;
      end else if ($urandom_range(0, 99) < 85) begin
        send_group();
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    // Reset, then wait for the table clearing pass to finish
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (!in_ready);

    write_default('1);

    // Directed: empty stack, skipped records, nested restores, clear
    send(CMD_GET,     '0,       '0,            '0);
    send(CMD_GET,     '1,       '0,            '1);
    send(CMD_RESTORE, '0,       '0,            '0);
    send(CMD_CLEAR,   '0,       '0,            '0);
    send(CMD_SET,     '1,       '0,            '1);
    send(CMD_SET,     '0,       '1,            8'd2);
    send(CMD_SET,     12'd7,    32'h0000_1234, 8'd3);
    send(CMD_SET,     12'd7,    32'h0000_5678, 8'd1);
    send(CMD_SET,     12'd7,    32'h0000_0009, 8'd0);
    send(CMD_GET,     12'd7,    '0,            '0);
    send(CMD_RESTORE, '0,       '0,            8'd3);
    send(CMD_GET,     12'd7,    '0,            '0);
    send(CMD_SET,     '1,       32'hA5A5_5A5A, 8'd4);
    send(CMD_RESTORE, '0,       '0,            8'd4);
    send(CMD_GET,     '1,       '0,            '0);
    send(CMD_RESTORE, '0,       '0,            8'd1);
    send(CMD_GET,     '1,       '0,            '0);
    send(CMD_GET,     '0,       '0,            '0);
    send(CMD_SET,     12'd100,  32'h8000_0001, 8'd2);
    send(CMD_SET,     12'd101,  32'h7FFF_FFFE, 8'd2);
    send(CMD_CLEAR,   '0,       '0,            '0);
    send(CMD_RESTORE, '0,       '0,            '0);
    send(CMD_GET,     12'd100,  '0,            '0);
    drain();

    // New default: unwritten entries follow it, written ones keep their value
    write_default('0);
    send(CMD_GET, '1,     '0, '0);
    send(CMD_GET, 12'd3,  '0, '0);
    drain();

    write_default($urandom);
    run_phase(300, 1'b0, 1'b1);
    drain();

    tx_idle_pct = 73;
    rx_idle_pct = 37;
    write_default(32'h8000_0000);
    run_phase(300, 1'b1, 1'b0);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_default($urandom);
    run_phase(300, 1'b0, 1'b1);
    drain();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tws_pkg.sv
design/tws_ram.sv
design/tws_ctrl.sv
design/table_with_level_save_stack_unit.sv
verif/tb_top.sv
